// File: hw/rtl/pnh_pkg.sv
// Package for the path name hash unit: mixing constants and the
// structs passed between pipeline stages. No dependencies.
package pnh_pkg;

   // Backslash and terminator detection masks, case fold mask and slash delta
   localparam logic [31:0] OnesBytes   = 32'h0101_0101;
   localparam logic [31:0] HighBytes   = 32'h8080_8080;
   localparam logic [31:0] BslashBytes = 32'h5C5C_5C5C;
   localparam logic [31:0] FoldMask    = 32'hDFDF_DFDF;
   localparam logic [31:0] SlashDelta  = 32'd45;

   // Mixing multipliers
   localparam logic [43:0] MixWordMul = 44'hFB8_C4D9_6501;
   localparam logic [26:0] MixAccMul  = 27'h633_D5F1;
   localparam logic [55:0] MixLenMul  = 56'hAE_5028_12AA_7333;

   // Halves of the wide multipliers, so each partial product stays narrow
   localparam logic [21:0] MixWordMulLo = MixWordMul[21:0];
   localparam logic [21:0] MixWordMulHi = MixWordMul[43:22];
   localparam logic [27:0] MixLenMulLo  = MixLenMul[27:0];
   localparam logic [27:0] MixLenMulHi  = MixLenMul[55:28];

   // Rewritten word mixed and shifted: bits 63:24 of the 64-bit product
   typedef struct packed {
      logic        last;
      logic [1:0]  idx;
      logic [39:0] term;
   } pnh_term_type;

   // Terminated name: accumulator sum before the length term, and the length
   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] len;
   } pnh_sum_type;

endpackage

// File: hw/rtl/pnh_req_if.sv
// Request channel carrying one 32-bit name word per handshake.
// No dependencies.
interface pnh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] name_word;

   modport source (output valid, output name_word, input ready);
   modport sink   (input valid, input name_word, output ready);
endinterface

// File: hw/rtl/pnh_rsp_if.sv
// Response channel carrying the hash of one terminated name.
// No dependencies.
interface pnh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_wide;
   logic [31:0] hash_folded;
   logic [31:0] name_length;

   modport source (output valid, output hash_wide, output hash_folded,
                   output name_length, input ready);
   modport sink   (input valid, input hash_wide, input hash_folded,
                   input name_length, output ready);
endinterface

// File: hw/rtl/pnh_front.sv
// Front end: input register, word rewrite, terminator detect and the
// constant word multiply split over two stages. Uses pnh_pkg, pnh_req_if.
module pnh_front (
   input  logic                 clock,
   input  logic                 reset,
   pnh_req_if.sink              req_chan,
   output logic                 term_valid,
   input  logic                 term_ready,
   output pnh_pkg::pnh_term_type term_item
);
   import pnh_pkg::*;

   logic        in_v_ff;
   logic [31:0] in_word_ff;
   logic        pr_v_ff;
   logic        pr_last_ff;
   logic [1:0]  pr_idx_ff;
   logic [53:0] pr_lo_ff;
   logic [53:0] pr_hi_ff;
   logic        tm_v_ff;
   pnh_term_type tm_item_ff;

   logic        in_free;
   logic        pr_free;
   logic        tm_free;
   logic [31:0] bs_x;
   logic [31:0] bs_flags;
   logic [31:0] fixed_word;
   logic [31:0] zero_hits;
   logic [31:0] keep_mask;
   logic [31:0] mix_word;
   logic        word_last;
   logic [1:0]  word_idx;
   logic [63:0] prod_sum;

   // stage hand-off: a stage loads when it is empty or its word moves on
   assign tm_free        = !tm_v_ff || term_ready;
   assign pr_free        = !pr_v_ff || tm_free;
   assign in_free        = !in_v_ff || pr_free;
   assign req_chan.ready = in_free;

   // backslash to slash, then case fold
   always_comb begin
      bs_x       = in_word_ff ^ BslashBytes;
      bs_flags   = ((~bs_x) >> 7) & ((bs_x - OnesBytes) >> 7) & OnesBytes;
      fixed_word = (in_word_ff - (bs_flags * SlashDelta)) & FoldMask;
   end

   // first zero byte: lowest hit of the terminator detector
   always_comb begin
      zero_hits = ~in_word_ff & (in_word_ff - OnesBytes) & HighBytes;
      word_last = |zero_hits;
      priority if (zero_hits[7]) begin
         word_idx  = 2'd0;
         keep_mask = 32'h0000_007F;
      end else if (zero_hits[15]) begin
         word_idx  = 2'd1;
         keep_mask = 32'h0000_7FFF;
      end else if (zero_hits[23]) begin
         word_idx  = 2'd2;
         keep_mask = 32'h007F_FFFF;
      end else begin
         word_idx  = 2'd3;
         keep_mask = 32'h7FFF_FFFF;
      end
      mix_word = word_last ? (fixed_word & keep_mask) : fixed_word;
   end

   // partial products recombined modulo 2^64
   assign prod_sum = 64'(pr_lo_ff) + (64'(pr_hi_ff) << 22);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         pr_v_ff <= 1'b0;
         tm_v_ff <= 1'b0;
      end else begin
         if (in_free) in_v_ff <= req_chan.valid;
         if (pr_free) pr_v_ff <= in_v_ff;
         if (tm_free) tm_v_ff <= pr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free) in_word_ff <= req_chan.name_word;
      if (pr_free) begin
         pr_last_ff <= word_last;
         pr_idx_ff  <= word_idx;
         pr_lo_ff   <= 54'(mix_word) * 54'(MixWordMulLo);
         pr_hi_ff   <= 54'(mix_word) * 54'(MixWordMulHi);
      end
      if (tm_free) begin
         tm_item_ff.last <= pr_last_ff;
         tm_item_ff.idx  <= pr_idx_ff;
         tm_item_ff.term <= prod_sum[63:24];
      end
   end

   assign term_valid = tm_v_ff;
   assign term_item  = tm_item_ff;

endmodule

// File: hw/rtl/pnh_accum.sv
// Accumulator stage: folds each mixed word into the running hash state
// and hands terminated names onward. Uses pnh_pkg.
module pnh_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 term_valid,
   output logic                 term_ready,
   input  pnh_pkg::pnh_term_type term_item,
   output logic                 sum_valid,
   input  logic                 sum_ready,
   output pnh_pkg::pnh_sum_type  sum_item
);
   import pnh_pkg::*;

   logic [63:0] acc_ff;
   logic [31:0] count_ff;
   logic        ls_v_ff;
   pnh_sum_type ls_item_ff;

   logic        ls_free;
   logic        fire;
   logic [63:0] acc_prod;
   logic [63:0] mix_sum;
   logic [63:0] acc_in;

   // only a terminating word needs room downstream
   assign ls_free    = !ls_v_ff || sum_ready;
   assign term_ready = !term_item.last || ls_free;
   assign fire       = term_valid && term_ready;

   // acc * multiplier modulo 2^64 from two narrow products; this loop sets fmax
   always_comb begin
      acc_prod = 64'(59'(acc_ff[31:0]) * 59'(MixAccMul))
               + {32'(acc_ff[63:32]) * 32'(MixAccMul), 32'd0};
      mix_sum  = acc_prod + 64'(term_item.term);
      acc_in   = mix_sum ^ (mix_sum >> 61);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
         ls_v_ff  <= 1'b0;
      end else begin
         if (fire) begin
            if (term_item.last) begin
               acc_ff   <= '0;
               count_ff <= '0;
            end else begin
               acc_ff   <= acc_in;
               count_ff <= count_ff + 32'd4;
            end
         end
         if (ls_free) ls_v_ff <= fire && term_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ls_free) begin
         ls_item_ff.sum <= mix_sum;
         ls_item_ff.len <= count_ff + 32'(term_item.idx);
      end
   end

   assign sum_valid = ls_v_ff;
   assign sum_item  = ls_item_ff;

   // a terminated name leaves the state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && term_item.last |=> acc_ff == '0 && count_ff == '0)
      else $error("hash state not cleared after terminator");

   // each inner word adds four bytes
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire && !term_item.last |=> count_ff == $past(count_ff) + 32'd4)
      else $error("byte count did not advance by four");

   // a held name result is not overwritten
   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      ls_v_ff && !sum_ready |=> ls_v_ff && $stable(ls_item_ff))
      else $error("pending name sum lost");

endmodule

// File: hw/rtl/pnh_final.sv
// Final stage: length multiply, subtraction and the response register.
// Uses pnh_pkg, pnh_rsp_if.
module pnh_final (
   input  logic                clock,
   input  logic                reset,
   input  logic                sum_valid,
   output logic                sum_ready,
   input  pnh_pkg::pnh_sum_type sum_item,
   pnh_rsp_if.source           rsp_chan
);
   import pnh_pkg::*;

   logic        lp_v_ff;
   logic [63:0] lp_sum_ff;
   logic [31:0] lp_len_ff;
   logic [59:0] lp_lo_ff;
   logic [59:0] lp_hi_ff;
   logic        out_v_ff;
   logic [63:0] out_hash_ff;
   logic [31:0] out_fold_ff;
   logic [31:0] out_len_ff;

   logic        out_take;
   logic        lp_free;
   logic [63:0] hash_in;

   assign out_take  = !out_v_ff || rsp_chan.ready;
   assign lp_free   = !lp_v_ff || out_take;
   assign sum_ready = lp_free;

   // hash = sum - len * multiplier, modulo 2^64
   assign hash_in = lp_sum_ff - (64'(lp_lo_ff) + (64'(lp_hi_ff) << 28));

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (lp_free)  lp_v_ff  <= sum_valid;
         if (out_take) out_v_ff <= lp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lp_free) begin
         lp_sum_ff <= sum_item.sum;
         lp_len_ff <= sum_item.len;
         lp_lo_ff  <= 60'(sum_item.len) * 60'(MixLenMulLo);
         lp_hi_ff  <= 60'(sum_item.len) * 60'(MixLenMulHi);
      end
      if (out_take) begin
         out_hash_ff <= hash_in;
         out_fold_ff <= hash_in[31:0] ^ hash_in[63:32];
         out_len_ff  <= lp_len_ff;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.hash_wide   = out_hash_ff;
   assign rsp_chan.hash_folded = out_fold_ff;
   assign rsp_chan.name_length = out_len_ff;

endmodule

// File: hw/rtl/path_name_hash64_unit.sv
// Top level of the path name hash unit: front end, accumulator, final stage.
// Uses pnh_pkg, pnh_req_if, pnh_rsp_if, pnh_front, pnh_accum, pnh_final.
//
//   channel    dir  word                                      per handshake
//   req_chan   in   name_word[31:0]                           one name word
//   rsp_chan   out  hash_wide[63:0] hash_folded name_length   one hashed name
//
// One word is taken per cycle when nothing is stalled.
// A terminating word reaches rsp_chan after it is accepted, through the input
// register, product, term, accumulator, length-multiply and response registers.
// The accumulator multiply-add-fold loop is the single-register recurrence.
// Reset (synchronous) clears valid flags, accumulator and byte count.
// A stalled response holds only terminating words; inner words keep flowing.
module path_name_hash64_unit (
   input  logic       clock,
   input  logic       reset,
   pnh_req_if.sink    req_chan,
   pnh_rsp_if.source  rsp_chan
);
   import pnh_pkg::*;

   logic         term_valid;
   logic         term_ready;
   pnh_term_type term_item;
   logic         sum_valid;
   logic         sum_ready;
   pnh_sum_type  sum_item;

   pnh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .term_valid (term_valid),
      .term_ready (term_ready),
      .term_item  (term_item)
   );

   pnh_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .term_valid (term_valid),
      .term_ready (term_ready),
      .term_item  (term_item),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum_item   (sum_item)
   );

   pnh_final u_final (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_item  (sum_item),
      .rsp_chan  (rsp_chan)
   );

endmodule
